FILE: sv/decimal_digit_frame_formatter_assert.svh
`ifndef DECIMAL_DIGIT_FRAME_FORMATTER_ASSERT_SVH
`define DECIMAL_DIGIT_FRAME_FORMATTER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define DDFF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define DDFF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ddff_pkg.sv
package ddff_pkg;

  // Display defaults and fixed field widths
  localparam int DIGITS_DEF = 8;
  localparam int IDX_W      = 3;
  localparam int NUM_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int ITER_W     = 5;
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(NUM_W - 1);

  // Code B digit codes
  localparam logic [3:0] CODE_ZERO  = 4'd0;
  localparam logic [3:0] CODE_DASH  = 4'd10;
  localparam logic [3:0] CODE_BLANK = 4'd15;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_DOT_MASK = 1'b0;
  localparam logic REG_DOTS_EN  = 1'b1;

  // Input item
  typedef struct packed {
    logic signed [NUM_W-1:0] number;
    logic [IDX_W-1:0]        first_digit;
    logic [IDX_W-1:0]        last_digit;
  } item_t;

  // Result item, one digit-register frame
  typedef struct packed {
    logic [3:0] register_address;
    logic [3:0] digit_code;
    logic       decimal_point;
    logic       last_frame;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_empty;
    logic conv_done;
    logic at_last;
  } stat_t;

endpackage

FILE: sv/ddff_regs.sv
module ddff_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddff_pkg::APB_AW-1:0] paddr,
  input  logic [ddff_pkg::APB_DW-1:0] pwdata,
  output logic [ddff_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [7:0]                  dot_digit_mask,
  output logic                        dots_enabled
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes on the access cycle of a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_digit_mask <= 8'd0;
      dots_enabled   <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        ddff_pkg::REG_DOT_MASK: dot_digit_mask <= pwdata[7:0];
        ddff_pkg::REG_DOTS_EN:  dots_enabled   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (paddr[2])
      ddff_pkg::REG_DOT_MASK: prdata = {24'd0, dot_digit_mask};
      ddff_pkg::REG_DOTS_EN:  prdata = {31'd0, dots_enabled};
      default:                prdata = '0;
    endcase
  end

endmodule

FILE: sv/ddff_ctrl.sv
module ddff_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ddff_pkg::stat_t  stat,
  output ddff_pkg::cmd_t   cmd,
  output logic             busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PREP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!stat.range_empty) state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (stat.conv_done) state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.at_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

FILE: sv/ddff_dp.sv
`include "decimal_digit_frame_formatter_assert.svh"

module ddff_dp #(
  parameter int DIGITS = ddff_pkg::DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ddff_pkg::cmd_t     cmd,
  output ddff_pkg::stat_t    stat,
  input  ddff_pkg::item_t    item,
  input  logic [7:0]         dot_digit_mask,
  input  logic               dots_enabled,
  output ddff_pkg::result_t  result,
  output logic               valid
);

  localparam int IW = ddff_pkg::IDX_W;
  localparam int NW = ddff_pkg::NUM_W;
  localparam int BW = ddff_pkg::BCD_W;
  localparam logic [IW-1:0] MAX_IDX = IW'(DIGITS - 1);

  // Item registers
  logic [IW-1:0]               first, last_c, idx;
  logic                        neg, neg_pend;
  logic [NW-1:0]               bin;
  logic [BW-1:0]               bcd;
  logic [ddff_pkg::ITER_W-1:0] iter;

  // Per-item results of the prep cycle
  logic          zero_on;
  logic [IW-1:0] zero_pos;
  logic [3:0]    rem;

  // Input decode at the accept edge
  logic [IW-1:0] in_last;
  logic [NW-1:0] in_mag;

  assign in_last = (item.last_digit > MAX_IDX) ? MAX_IDX : item.last_digit;
  assign in_mag  = item.number[NW-1] ? (NW'(0) - NW'(item.number)) : NW'(item.number);

  assign stat.range_empty = (item.first_digit > in_last);
  assign stat.conv_done   = (iter == ddff_pkg::LAST_ITER);
  assign stat.at_last     = (idx == last_c);

  // Double-dabble add-3 correction, one bit per step
  logic [BW-1:0] bcd_adj;
  always_comb begin
    for (int j = 0; j < ddff_pkg::BCD_DIGITS; j++) begin
      bcd_adj[4*j +: 4] = (bcd[4*j +: 4] >= 4'd5) ? (bcd[4*j +: 4] + 4'd3) : bcd[4*j +: 4];
    end
  end

  // Prep: lowest dot digit in range, magnitude test, significant digit count
  logic          dot_found, mag_big;
  logic [IW-1:0] dot_pos, dot_off;
  logic [3:0]    ndig;
  always_comb begin
    dot_found = 1'b0;
    dot_pos   = '0;
    for (int d = 7; d >= 0; d--) begin
      if (IW'(d) >= first && IW'(d) <= last_c && dot_digit_mask[d]) begin
        dot_found = 1'b1;
        dot_pos   = IW'(d);
      end
    end
    dot_off = dot_pos - first;
    mag_big = 1'b0;
    ndig    = 4'd1;
    for (int j = 0; j < ddff_pkg::BCD_DIGITS; j++) begin
      if (4'(j) >= {1'b0, dot_off} && bcd[4*j +: 4] != 4'd0) mag_big = 1'b1;
      if (bcd[4*j +: 4] != 4'd0) ndig = 4'(j + 1);
    end
  end

  // Frame content
  logic take_digit, take_dash;
  always_comb begin
    take_digit = 1'b0;
    take_dash  = 1'b0;
    result.register_address = {1'b0, idx} + 4'd1;
    result.last_frame       = (idx == last_c);
    if (zero_on && idx == zero_pos) begin
      result.digit_code    = ddff_pkg::CODE_ZERO;
      result.decimal_point = 1'b1;
    end else if (rem != 4'd0) begin
      take_digit           = 1'b1;
      result.digit_code    = bcd[3:0];
      result.decimal_point = dots_enabled && dot_digit_mask[idx];
    end else if (neg_pend) begin
      take_dash            = 1'b1;
      result.digit_code    = ddff_pkg::CODE_DASH;
      result.decimal_point = dots_enabled && dot_digit_mask[idx];
    end else begin
      result.digit_code    = ddff_pkg::CODE_BLANK;
      result.decimal_point = 1'b0;
    end
  end

  assign valid = cmd.emit;

  // Iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (cmd.load) begin
      iter <= '0;
    end else if (cmd.step) begin
      iter <= iter + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first    <= item.first_digit;
      last_c   <= in_last;
      idx      <= item.first_digit;
      neg      <= item.number[NW-1];
      neg_pend <= item.number[NW-1];
      bin      <= in_mag;
      bcd      <= '0;
    end else if (cmd.step) begin
      bcd <= {bcd_adj[BW-2:0], bin[NW-1]};
      bin <= {bin[NW-2:0], 1'b0};
    end else if (cmd.prep) begin
      zero_on  <= dots_enabled && dot_found && (neg || !mag_big);
      zero_pos <= dot_pos;
      rem      <= ndig;
    end else if (cmd.emit) begin
      idx <= idx + 1'b1;
      if (take_digit) begin
        bcd <= {4'd0, bcd[BW-1:4]};
        rem <= rem - 4'd1;
      end
      if (take_dash) neg_pend <= 1'b0;
    end
  end

  `DDFF_ASSERT_IMPL(a_emit_in_range, clk, rst, cmd.emit, idx >= first && idx <= last_c, "frame index outside range")
  `DDFF_ASSERT_NEXT(a_emit_advance, clk, rst, cmd.emit && !stat.at_last, idx == $past(idx) + 3'd1, "frame index did not advance")
  `DDFF_ASSERT_NEXT(a_prep_count, clk, rst, cmd.prep, rem >= 4'd1 && rem <= 4'd10, "bad significant digit count")

endmodule

FILE: sv/decimal_digit_frame_formatter.sv
// Decimal digit frame formatter. Pulse start with an item while busy is low;
// the item is taken on that edge and busy rises unless the digit range is
// empty (then no frames follow and the block stays free). The signed number is
// converted to BCD by a shift-and-add-3 loop, one bit per cycle, then a prep
// state, then one frame per digit of the range, one per cycle, marked by valid
// for exactly one cycle each. The receiver cannot stall: every valid cycle
// must be captured. Configuration writes go through the APB port; the user must
// make them only while busy is low, as the block does not enforce this.
module decimal_digit_frame_formatter #(
  parameter int DIGITS = ddff_pkg::DIGITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ddff_pkg::item_t             item,
  output ddff_pkg::result_t           result,
  output logic                        valid,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ddff_pkg::APB_AW-1:0] paddr,
  input  logic [ddff_pkg::APB_DW-1:0] pwdata,
  output logic [ddff_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  ddff_pkg::cmd_t  cmd;
  ddff_pkg::stat_t stat;
  logic [7:0]      dot_digit_mask;
  logic            dots_enabled;

  // Configuration registers
  ddff_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .dot_digit_mask (dot_digit_mask),
    .dots_enabled   (dots_enabled)
  );

  // Sequencer
  ddff_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Conversion and frame datapath
  ddff_dp #(
    .DIGITS (DIGITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .item           (item),
    .dot_digit_mask (dot_digit_mask),
    .dots_enabled   (dots_enabled),
    .result         (result),
    .valid          (valid)
  );

endmodule

FILE: bench/decimal_digit_frame_formatter_tb.sv
`timescale 1ns / 1ps

module decimal_digit_frame_formatter_tb;

  localparam logic [ddff_pkg::APB_AW-1:0] ADDR_DOT_MASK = {ddff_pkg::REG_DOT_MASK, 2'b00};
  localparam logic [ddff_pkg::APB_AW-1:0] ADDR_DOTS_EN  = {ddff_pkg::REG_DOTS_EN, 2'b00};
  localparam int SETTLE_CYCLES = 48;    // worst item latency plus margin
  localparam int STALL_LIMIT   = 3000;  // cycles without any transfer
  localparam int BATCH_ITEMS   = 37;

  typedef enum logic [1:0] {JOB_ITEM, JOB_WRITE, JOB_DRAIN, JOB_PACE} job_kind_t;
  typedef enum logic [1:0] {APB_IDLE, APB_SETUP, APB_ACCESS} apb_state_t;

  typedef struct {
    job_kind_t                   kind;
    ddff_pkg::item_t             data;
    logic [ddff_pkg::APB_AW-1:0] addr;
    logic [ddff_pkg::APB_DW-1:0] wdata;
    int unsigned                 pct;
  } job_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  ddff_pkg::item_t             item = '0;
  ddff_pkg::result_t           result;
  logic                        valid;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [ddff_pkg::APB_AW-1:0] paddr = '0;
  logic [ddff_pkg::APB_DW-1:0] pwdata = '0;
  logic [ddff_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  job_t              pending_jobs[$];
  ddff_pkg::result_t expected_frames[$];
  logic [7:0]        cfg_mask = 8'h00;
  logic              cfg_dots_en = 1'b0;
  apb_state_t        apb_state = APB_IDLE;
  int unsigned       idle_pct = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       items_queued = 0;
  int unsigned       items_taken = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       fault_count = 0;

  decimal_digit_frame_formatter u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .result  (result),
    .valid   (valid),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Works out the frames one accepted item produces under the current settings
  function automatic void format_frames(ddff_pkg::item_t it);
    logic [3:0]        text [0:11];
    int unsigned       len;
    int unsigned       used;
    int unsigned       zero_pos;
    logic              zero_on;
    logic              found;
    logic              neg;
    logic [31:0]       mag;
    longint            limit;
    longint            val;
    ddff_pkg::result_t fr;
    len = 0;
    used = 0;
    zero_pos = 0;
    zero_on = 1'b0;
    found = 1'b0;
    if (it.first_digit > it.last_digit) return;

    // decimal text, least significant character first
    neg = it.number[ddff_pkg::NUM_W-1];
    mag = neg ? 32'd0 - it.number : it.number;
    for (int k = 0; k < ddff_pkg::BCD_DIGITS; k++) begin
      if (k == 0 || mag != 0) begin
        text[len] = 4'(mag % 10);
        len++;
        mag = mag / 10;
      end
    end
    if (neg) begin
      text[len] = ddff_pkg::CODE_DASH;
      len++;
    end

    // leading zero goes on the lowest dot digit of the range for small values
    if (cfg_dots_en) begin
      val = longint'($signed(it.number));
      for (int d = 0; d < ddff_pkg::DIGITS_DEF; d++) begin
        if (!found && d >= it.first_digit && d <= it.last_digit && cfg_mask[d]) begin
          found = 1'b1;
          limit = 1;
          for (int k = it.first_digit; k < d; k++) limit = limit * 10;
          if (val < limit) begin
            zero_on = 1'b1;
            zero_pos = d;
          end
        end
      end
    end

    for (int d = 0; d < ddff_pkg::DIGITS_DEF; d++) begin
      if (d >= it.first_digit && d <= it.last_digit) begin
        fr.register_address = 4'(d + 1);
        if (zero_on && d == zero_pos) begin
          fr.digit_code = ddff_pkg::CODE_ZERO;
          fr.decimal_point = 1'b1;
        end else if (used < len) begin
          fr.digit_code = text[used];
          fr.decimal_point = cfg_dots_en && cfg_mask[d];
          used++;
        end else begin
          fr.digit_code = ddff_pkg::CODE_BLANK;
          fr.decimal_point = 1'b0;
        end
        fr.last_frame = (d == it.last_digit);
        expected_frames.push_back(fr);
      end
    end
  endfunction

  // Driver: items on start/busy, register writes on APB, pacing and drains
  always @(posedge clk) begin : driver
    logic taken;
    job_t job;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
      item <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      apb_state = APB_IDLE;
      quiet_cycles = 0;
    end else begin
      quiet_cycles = (taken || valid) ? 0 : quiet_cycles + 1;
      if (taken) begin
        format_frames(item);
        items_taken++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_DOT_MASK) cfg_mask = pwdata[7:0];
        else if (paddr == ADDR_DOTS_EN) cfg_dots_en = pwdata[0];
      end

      if (start && !taken) begin
        // hold the item until the transfer
      end else if (apb_state == APB_SETUP) begin
        penable <= 1'b1;
        apb_state = APB_ACCESS;
      end else if (apb_state == APB_ACCESS) begin
        if (pready) begin
          psel <= 1'b0;
          penable <= 1'b0;
          pwrite <= 1'b0;
          apb_state = APB_IDLE;
        end
      end else if (pending_jobs.size() == 0) begin
        start <= 1'b0;
      end else begin
        job = pending_jobs[0];
        case (job.kind)
          JOB_PACE: begin
            idle_pct = job.pct;
            job = pending_jobs.pop_front();
            start <= 1'b0;
          end
          JOB_DRAIN: begin
            if (expected_frames.size() == 0 && !busy) job = pending_jobs.pop_front();
            start <= 1'b0;
          end
          JOB_WRITE: begin
            // registers change only once the block has gone quiet
            if (expected_frames.size() == 0 && !busy && quiet_cycles >= SETTLE_CYCLES) begin
              psel <= 1'b1;
              penable <= 1'b0;
              pwrite <= 1'b1;
              paddr <= job.addr;
              pwdata <= job.wdata;
              apb_state = APB_SETUP;
              job = pending_jobs.pop_front();
            end
            start <= 1'b0;
          end
          default: begin
            if ($urandom_range(99) < idle_pct) begin
              start <= 1'b0;
            end else begin
              job = pending_jobs.pop_front();
              start <= 1'b1;
              item <= job.data;
            end
          end
        endcase
      end
    end
  end

  // Monitor: every strobed frame against the oldest expected frame
  always @(posedge clk) begin : monitor
    ddff_pkg::result_t want;
    if (!rst && valid) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected frame, expected none, got %p", $time, result);
        fault_count++;
      end else begin
        want = expected_frames.pop_front();
        if (result.register_address !== want.register_address) begin
          $display("%0t: register_address expected %0d, got %0d", $time,
                   want.register_address, result.register_address);
          fault_count++;
        end
        if (result.digit_code !== want.digit_code) begin
          $display("%0t: digit_code expected %0d, got %0d (address %0d)", $time,
                   want.digit_code, result.digit_code, want.register_address);
          fault_count++;
        end
        if (result.decimal_point !== want.decimal_point) begin
          $display("%0t: decimal_point expected %0b, got %0b (address %0d)", $time,
                   want.decimal_point, result.decimal_point, want.register_address);
          fault_count++;
        end
        if (result.last_frame !== want.last_frame) begin
          $display("%0t: last_frame expected %0b, got %0b (address %0d)", $time,
                   want.last_frame, result.last_frame, want.register_address);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_item(input logic [31:0] number, input int first, input int last);
    job_t job;
    job.kind = JOB_ITEM;
    job.data.number = number;
    job.data.first_digit = ddff_pkg::IDX_W'(first);
    job.data.last_digit = ddff_pkg::IDX_W'(last);
    job.addr = '0;
    job.wdata = '0;
    job.pct = 0;
    pending_jobs.push_back(job);
    items_queued++;
  endtask

  task automatic add_job(input job_kind_t kind, input logic [ddff_pkg::APB_AW-1:0] addr,
                         input logic [ddff_pkg::APB_DW-1:0] wdata, input int unsigned pct);
    job_t job;
    job.kind = kind;
    job.data = '0;
    job.addr = addr;
    job.wdata = wdata;
    job.pct = pct;
    pending_jobs.push_back(job);
  endtask

  task automatic add_settings(input logic [7:0] mask, input logic dots_en);
    add_job(JOB_WRITE, ADDR_DOT_MASK, {24'h0, mask}, 0);
    add_job(JOB_WRITE, ADDR_DOTS_EN, {31'h0, dots_en}, 0);
  endtask

  // Numbers that favor short texts and the power-of-ten thresholds
  function automatic logic [31:0] pick_number();
    logic [31:0] pow;
    pow = 1;
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(9);
      2: return $urandom_range(99999);
      3: return 32'd0 - $urandom_range(9999);
      4: begin
        repeat ($urandom_range(9)) pow = pow * 10;
        return ($urandom_range(1) ? pow : 32'd0 - pow) + $urandom_range(2) - 1;
      end
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  initial begin : stimulus
    int first;
    int last;
    int made;
    int unsigned phase_pct [0:2];
    phase_pct[0] = 14;
    phase_pct[1] = 47;
    phase_pct[2] = 0;

    // directed: reset settings, dots off
    add_job(JOB_PACE, '0, '0, phase_pct[0]);
    add_item(32'd0, 0, 7);
    add_item(32'h7FFF_FFFF, 0, 7);
    add_item(32'h8000_0000, 0, 7);
    add_item(32'hFFFF_FFFF, 3, 3);
    add_item(32'd12345, 2, 5);
    add_item(32'd5, 6, 2);
    add_item(32'd99999999, 7, 7);
    // every digit a dot digit
    add_settings(8'hFF, 1'b1);
    add_item(32'd0, 0, 7);
    add_item(32'd7, 0, 7);
    add_item(-32'sd42, 1, 4);
    // single dot digit in the middle
    add_settings(8'h10, 1'b1);
    add_item(32'd123, 2, 7);
    add_item(32'd45, 2, 7);
    add_item(32'd99, 4, 7);
    add_item(32'd12, 0, 3);
    add_item(32'h8000_0000, 0, 7);
    add_settings(8'h00, 1'b1);
    add_item(32'd5, 0, 7);
    // mask set but dots off shows no points
    add_settings(8'hA5, 1'b0);
    add_item(32'd5, 0, 7);
    add_settings(8'h80, 1'b1);
    add_item(32'd3, 0, 7);
    add_item(32'h7FFF_FFFF, 0, 7);
    add_item(32'd1000, 7, 0);
    add_item(-32'sd9, 0, 0);
    add_job(JOB_DRAIN, '0, '0, 0);

    // random part, three pacing phases with fresh settings per batch
    for (int phase = 0; phase < 3; phase++) begin
      add_job(JOB_PACE, '0, '0, phase_pct[phase]);
      for (int batch = 0; batch < 2; batch++) begin
        add_settings(8'($urandom), $urandom_range(3) != 0);
        made = 0;
        while (made < BATCH_ITEMS) begin
          first = $urandom_range(7);
          last = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(7, first);
          add_item(pick_number(), first, last);
          if (first <= last) made++;
        end
      end
      add_job(JOB_DRAIN, '0, '0, 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_jobs.size() != 0 || items_taken != items_queued
           || apb_state != APB_IDLE)
      @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
